FILE: rtl/mexp_pkg.sv
// Shared types for the modular exponentiation block: multiplier opcodes, command and status.
package mexp_pkg;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MUL,
        OP_SQR
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    start;
        t_mul_op op;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic e_zero;
        logic e_lsb;
        logic e_last;
    } t_dp_status;

endpackage

FILE: rtl/mexp_regs.sv
// Configuration register file: modulus and exponent behind an APB-style port.
module mexp_regs #(
    parameter int OPERAND_WIDTH = 32,
    parameter int DATA_W        = 32,
    parameter int ADDR_W        = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    output logic [OPERAND_WIDTH-1:0] o_modulus,
    output logic [OPERAND_WIDTH-1:0] o_exponent
);

    logic [OPERAND_WIDTH-1:0] r_modulus;
    logic [OPERAND_WIDTH-1:0] r_exponent;
    logic                     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= OPERAND_WIDTH'(2);
            r_exponent <= OPERAND_WIDTH'(1);
        end else if (wr_en) begin
            if (paddr[ADDR_W-1]) begin
                r_exponent <= pwdata[OPERAND_WIDTH-1:0];
            end else begin
                r_modulus <= pwdata[OPERAND_WIDTH-1:0];
            end
        end
    end

    assign prdata     = paddr[ADDR_W-1] ? DATA_W'(r_exponent) : DATA_W'(r_modulus);
    assign o_modulus  = r_modulus;
    assign o_exponent = r_exponent;

endmodule

FILE: rtl/mexp_ctrl.sv
// Sequencer for square-and-multiply: reduce, a multiply per set exponent bit, a square per bit below its top set bit.
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_CHECK,
        S_MUL,
        S_SQR,
        S_EMIT
    } t_state;

    t_state  r_state;
    logic    r_start;
    t_mul_op r_op;
    logic    r_out_valid;
    logic    load;
    logic    emit;

    assign load = (r_state == S_IDLE) && i_in_valid;
    assign emit = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_op        <= OP_REDUCE;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (load) begin
                        r_state <= S_RED;
                        r_start <= 1'b1;
                        r_op    <= OP_REDUCE;
                    end
                end
                S_RED: begin
                    if (i_status.done) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (i_status.e_zero) begin
                        r_state <= S_EMIT;
                    end else if (i_status.e_lsb) begin
                        r_state <= S_MUL;
                        r_start <= 1'b1;
                        r_op    <= OP_MUL;
                    end else begin
                        r_state <= S_SQR;
                        r_start <= 1'b1;
                        r_op    <= OP_SQR;
                    end
                end
                S_MUL: begin
                    if (i_status.done) begin
                        if (i_status.e_last) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SQR;
                            r_start <= 1'b1;
                            r_op    <= OP_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (i_status.done) r_state <= S_CHECK;
                end
                S_EMIT: begin
                    if (emit) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = load;
    assign o_cmd.start = r_start;
    assign o_cmd.op    = r_op;
    assign o_cmd.emit  = emit;

endmodule

FILE: rtl/mexp_dp.sv
// Datapath: base, accumulator, exponent shifter and a bit-serial modular multiplier.
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [31:0]              i_value,
    input  logic [OPERAND_WIDTH-1:0] i_modulus,
    input  logic [OPERAND_WIDTH-1:0] i_exponent,
    output t_dp_status               o_status,
    output logic [31:0]              o_result
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_base;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_exp;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_r;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    t_mul_op          r_op;
    logic [31:0]      r_result;
    logic [W-1:0]     dbl;
    logic [W-1:0]     n_r;
    logic             m_one;

    // (x + y) mod m for x, y below m; a zero modulus wraps at the operand width
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        logic [W:0] t;
        s = {1'b0, x} + {1'b0, y};
        t = s - {1'b0, m};
        if ((m != '0) && (s >= {1'b0, m})) return t[W-1:0];
        return s[W-1:0];
    endfunction

    assign dbl   = add_mod(r_r, r_r, i_modulus);
    assign n_r   = r_b[W-1] ? add_mod(dbl, r_a, i_modulus) : dbl;
    assign m_one = (i_modulus == W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load) begin
                r_base <= W'(i_value);
                r_acc  <= W'(1);
                r_exp  <= i_exponent;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_r    <= '0;
                r_op   <= i_cmd.op;
                unique case (i_cmd.op)
                    OP_REDUCE: begin
                        r_a <= W'(1);
                        r_b <= r_base;
                    end
                    OP_MUL: begin
                        r_a <= r_acc;
                        r_b <= r_base;
                    end
                    default: begin
                        r_a <= r_base;
                        r_b <= r_base;
                    end
                endcase
            end else if (r_busy) begin
                r_r   <= n_r;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    unique case (r_op)
                        OP_MUL: r_acc <= n_r;
                        OP_SQR: begin
                            r_base <= n_r;
                            r_exp  <= r_exp >> 1;
                        end
                        default: r_base <= n_r;
                    endcase
                end
            end
            if (i_cmd.emit) begin
                r_result <= m_one ? 32'd0 : 32'(r_acc);
            end
        end
    end

    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;
    assign o_status.e_zero = (r_exp == '0);
    assign o_status.e_lsb  = r_exp[0];
    assign o_status.e_last = ((r_exp >> 1) == '0);
    assign o_result        = r_result;

endmodule

FILE: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: config port, sequencer, datapath, checks.
//
// Raises each input request i_value to the exponent register modulo the modulus register
// (right-to-left square-and-multiply) and returns the residue on o_result.
// Input: i_valid / o_stall; a request is taken when i_valid is high and o_stall low.
// Output: o_valid / i_stall; a result is taken when o_valid is high and i_stall low.
// Config: APB-style, modulus at byte 0, exponent at byte 4 (8 when OPERAND_WIDTH > 32);
// write only while idle.
// Work: one shared bit-serial multiplier sets the rate; each product is a start, W steps
// and a done. A request costs one initial reduction, one square per exponent bit below
// its top set bit, one multiply per set bit and one check per exponent bit (at least
// one). The next request can be taken in the cycle after the result reaches the output
// register at the earliest.
// One request is in work at a time; o_stall is high from acceptance until the result
// is moved to the output register. A held result does not block the next request, but a
// finished result waits in the sequencer while the output register is still stalled.
// Reset (synchronous, active low) sets modulus 2, exponent 1 and empties the block.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [((OPERAND_WIDTH > 32) ? 4 : 3)-1:0]  paddr,
    input  logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                    pready,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [31:0]                             i_value,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [31:0]                             o_result
);

    localparam int DATA_W = (OPERAND_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_W = (OPERAND_WIDTH > 32) ? 4 : 3;

    logic [OPERAND_WIDTH-1:0] modulus;
    logic [OPERAND_WIDTH-1:0] exponent;
    t_dp_cmd                  cmd;
    t_dp_status               status;

    mexp_regs #(
        .OPERAND_WIDTH(OPERAND_WIDTH),
        .DATA_W       (DATA_W),
        .ADDR_W       (ADDR_W)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_modulus (modulus),
        .o_exponent(exponent)
    );

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .o_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mexp_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_value   (i_value),
        .i_modulus (modulus),
        .i_exponent(exponent),
        .o_status  (status),
        .o_result  (o_result)
    );

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a request was taken");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.busy |-> o_stall)
        else $error("multiplier busy while input is open");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> !status.busy)
        else $error("multiplier started while busy");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_valid)
        else $error("result written but not presented");

endmodule
